// File: hw/rtl/gtd_pkg.sv
// Shared types and constants for the Goertzel tone detector.
// Used by gtd_mac and goertzel_tone_detector_unit; no dependencies.
`timescale 1ns / 1ps

package gtd_pkg;

    localparam int COEF_FRAC_BITS = 15;
    localparam int MAX_BLOCK      = 255;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 17;
    localparam int LEN_W    = 8;
    localparam int THR_W    = 48;
    localparam int ENERGY_W = 48;
    localparam int DELAY_W  = 40;
    localparam int CFG_W    = 48;
    localparam int CFG_IDX_W = 2;

    // 20-bit limbs carried in a 21-bit signed multiplier operand
    localparam int LIMB_W = 20;
    localparam int MUL_W  = LIMB_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int CQ_W   = 3 * LIMB_W;
    // room for (q1^2 + q2^2) << F less the cross term
    localparam int ACC_W  = 86 + COEF_FRAC_BITS;
    // resonator sum before saturation
    localparam int Q0_W   = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_COEFFICIENT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_THRESHOLD = 2'd2;

    localparam logic signed [COEF_W-1:0] COEF_RESET      = 17'sd0;
    localparam logic [LEN_W-1:0]         LEN_RESET       = 8'd102;
    localparam logic [THR_W-1:0]         THRESHOLD_RESET = 48'd1073742;

    // product alignment within the accumulator
    typedef enum logic [2:0] {
        SH_0,
        SH_F,
        SH_20,
        SH_20F,
        SH_40,
        SH_40F,
        SH_60
    } shift_t;

    typedef struct packed {
        logic                     valid;
        logic                     first;  // start a fresh sum
        logic                     rnd;    // fresh sum starts at half an LSB of the result
        logic                     neg;    // subtract the product
        shift_t                   shift;
        logic signed [MUL_W-1:0]  a;
        logic signed [MUL_W-1:0]  b;
    } mac_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RES,
        ST_RES_DONE,
        ST_CQ,
        ST_CQ_DONE,
        ST_EN,
        ST_EN_DONE
    } state_t;

endpackage

// File: hw/rtl/goertzel_tone_detector_unit.sv
// Goertzel tone detector top level: configuration registers, sequencer,
// resonator state and result register. Depends on gtd_pkg and gtd_mac.
`timescale 1ns / 1ps

// Usage
// Input words (s_sample, signed 16-bit PCM) are taken on s_valid & s_ready.
// Each sample runs the resonator on one shared 21x21 multiplier: two
// multiplies, then the product and accumulator registers and the delay
// update; s_ready stays low until that is done, so a new sample is taken
// only after the last one is through. The sample that completes a block
// also runs the energy sum, 16 more multiplies on the same unit, before
// m_valid rises.
// The result word (m_block_energy, m_tone_present) sits in an output register
// until m_ready; the next sample is taken meanwhile. A further block result
// waits in the sequencer, input held off, until that register frees.
// Configuration: cfg_index / cfg_data on cfg_valid, always ready; 0 is the
// coefficient (Q2.15), 1 the block length, 2 the energy threshold, others
// are ignored. Write only while idle.
// Reset (aresetn low, synchronous) clears the delays, counter and result
// valid, and restores register defaults: coefficient 0, length 102,
// threshold 1073742.

module goertzel_tone_detector_unit (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [gtd_pkg::SAMPLE_W-1:0] s_sample,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gtd_pkg::ENERGY_W-1:0]        m_block_energy,
    output logic                                m_tone_present,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gtd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gtd_pkg::CFG_W-1:0]           cfg_data
);
    import gtd_pkg::*;

    logic signed [COEF_W-1:0]   coef_reg;
    logic [LEN_W-1:0]           block_length_reg;
    logic [THR_W-1:0]           threshold_reg;

    logic signed [DELAY_W-1:0]  delay_one_reg;
    logic signed [DELAY_W-1:0]  delay_two_reg;
    logic [LEN_W-1:0]           counter_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [CQ_W-1:0]     cq_reg;

    state_t                     state_reg;
    state_t                     state_next;
    logic [3:0]                 step_reg;
    logic [3:0]                 step_next;

    logic                       m_valid_reg;
    logic [ENERGY_W-1:0]        energy_reg;
    logic                       tone_reg;

    mac_op_t                    mac_op;
    logic                       mac_busy;
    logic signed [ACC_W-1:0]    mac_acc;

    logic signed [MUL_W-1:0]    coef_l;
    logic signed [MUL_W-1:0]    d1_lo, d1_hi, d2_lo, d2_hi;
    logic signed [MUL_W-1:0]    cq0, cq1, cq2;

    logic signed [ACC_W-1:0]    acc_shr;
    logic signed [Q0_W-1:0]     q0_wide;
    logic signed [DELAY_W-1:0]  q0_sat;
    logic [LEN_W-1:0]           cnt_inc;
    logic [LEN_W-1:0]           len_eff;
    logic                       block_end;
    logic [ENERGY_W-1:0]        energy_sat;
    logic                       out_free;
    logic                       res_update;
    logic                       cq_load;
    logic                       result_load;

    gtd_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (mac_op),
        .busy    (mac_busy),
        .acc     (mac_acc)
    );

    // multiplier operands: low limbs unsigned, top limb signed
    assign coef_l = MUL_W'(coef_reg);
    assign d1_lo  = {1'b0, delay_one_reg[LIMB_W-1:0]};
    assign d1_hi  = {delay_one_reg[DELAY_W-1], delay_one_reg[DELAY_W-1:LIMB_W]};
    assign d2_lo  = {1'b0, delay_two_reg[LIMB_W-1:0]};
    assign d2_hi  = {delay_two_reg[DELAY_W-1], delay_two_reg[DELAY_W-1:LIMB_W]};
    assign cq0    = {1'b0, cq_reg[LIMB_W-1:0]};
    assign cq1    = {1'b0, cq_reg[2*LIMB_W-1:LIMB_W]};
    assign cq2    = {cq_reg[CQ_W-1], cq_reg[CQ_W-1:2*LIMB_W]};

    // resonator update and block end
    always_comb begin
        acc_shr = mac_acc >>> COEF_FRAC_BITS;
        q0_wide = acc_shr[Q0_W-1:0] - Q0_W'(delay_two_reg) + Q0_W'(sample_reg);
        if (q0_wide[Q0_W-1] && !(&q0_wide[Q0_W-2:DELAY_W-1])) begin
            q0_sat = {1'b1, {(DELAY_W-1){1'b0}}};
        end else if (!q0_wide[Q0_W-1] && (|q0_wide[Q0_W-2:DELAY_W-1])) begin
            q0_sat = {1'b0, {(DELAY_W-1){1'b1}}};
        end else begin
            q0_sat = q0_wide[DELAY_W-1:0];
        end

        cnt_inc = counter_reg + 1'b1;
        if (int'(block_length_reg) > MAX_BLOCK) begin
            len_eff = LEN_W'(MAX_BLOCK);
        end else if (block_length_reg == '0) begin
            len_eff = LEN_W'(1);
        end else begin
            len_eff = block_length_reg;
        end
        block_end = (cnt_inc >= len_eff);

        if (acc_shr[ACC_W-1]) begin
            energy_sat = '0;
        end else if (|acc_shr[ACC_W-2:ENERGY_W]) begin
            energy_sat = '1;
        end else begin
            energy_sat = acc_shr[ENERGY_W-1:0];
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_RES;
            end
            ST_RES: begin
                if (step_reg == 4'd1) state_next = ST_RES_DONE;
            end
            ST_RES_DONE: begin
                if (!mac_busy) state_next = block_end ? ST_CQ : ST_IDLE;
            end
            ST_CQ: begin
                if (step_reg == 4'd1) state_next = ST_CQ_DONE;
            end
            ST_CQ_DONE: begin
                if (!mac_busy) state_next = ST_EN;
            end
            ST_EN: begin
                if (step_reg == 4'd13) state_next = ST_EN_DONE;
            end
            ST_EN_DONE: begin
                if (!mac_busy && out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: multiplier schedule and register strobes
    always_comb begin
        mac_op      = '0;
        step_next   = 4'd0;
        s_ready     = 1'b0;
        res_update  = 1'b0;
        cq_load     = 1'b0;
        result_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_RES, ST_CQ: begin
                // coef * delay_one, rounded only for the resonator
                mac_op.valid = 1'b1;
                mac_op.first = (step_reg == 4'd0);
                mac_op.rnd   = (state_reg == ST_RES);
                mac_op.a     = coef_l;
                mac_op.b     = (step_reg == 4'd0) ? d1_lo : d1_hi;
                mac_op.shift = (step_reg == 4'd0) ? SH_0 : SH_20;
                step_next    = (step_reg == 4'd1) ? 4'd0 : step_reg + 4'd1;
            end
            ST_RES_DONE: begin
                res_update = !mac_busy;
            end
            ST_CQ_DONE: begin
                cq_load = !mac_busy;
            end
            ST_EN: begin
                // (q1^2 + q2^2) << F - (coef*q1)*q2, plus rounding half
                mac_op.valid = 1'b1;
                step_next    = (step_reg == 4'd13) ? 4'd0 : step_reg + 4'd1;
                case (step_reg)
                    4'd0: begin
                        mac_op.first = 1'b1;
                        mac_op.rnd   = 1'b1;
                        mac_op.a = d1_lo; mac_op.b = d1_lo; mac_op.shift = SH_F;
                    end
                    4'd1: begin mac_op.a = d1_lo; mac_op.b = d1_hi; mac_op.shift = SH_20F; end
                    4'd2: begin mac_op.a = d1_hi; mac_op.b = d1_lo; mac_op.shift = SH_20F; end
                    4'd3: begin mac_op.a = d1_hi; mac_op.b = d1_hi; mac_op.shift = SH_40F; end
                    4'd4: begin mac_op.a = d2_lo; mac_op.b = d2_lo; mac_op.shift = SH_F;   end
                    4'd5: begin mac_op.a = d2_lo; mac_op.b = d2_hi; mac_op.shift = SH_20F; end
                    4'd6: begin mac_op.a = d2_hi; mac_op.b = d2_lo; mac_op.shift = SH_20F; end
                    4'd7: begin mac_op.a = d2_hi; mac_op.b = d2_hi; mac_op.shift = SH_40F; end
                    4'd8: begin
                        mac_op.neg = 1'b1; mac_op.a = cq0; mac_op.b = d2_lo; mac_op.shift = SH_0;
                    end
                    4'd9: begin
                        mac_op.neg = 1'b1; mac_op.a = cq0; mac_op.b = d2_hi; mac_op.shift = SH_20;
                    end
                    4'd10: begin
                        mac_op.neg = 1'b1; mac_op.a = cq1; mac_op.b = d2_lo; mac_op.shift = SH_20;
                    end
                    4'd11: begin
                        mac_op.neg = 1'b1; mac_op.a = cq1; mac_op.b = d2_hi; mac_op.shift = SH_40;
                    end
                    4'd12: begin
                        mac_op.neg = 1'b1; mac_op.a = cq2; mac_op.b = d2_lo; mac_op.shift = SH_40;
                    end
                    4'd13: begin
                        mac_op.neg = 1'b1; mac_op.a = cq2; mac_op.b = d2_hi; mac_op.shift = SH_60;
                    end
                    default: mac_op.valid = 1'b0;
                endcase
            end
            ST_EN_DONE: begin
                result_load = !mac_busy && out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= 4'd0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg         <= COEF_RESET;
            block_length_reg <= LEN_RESET;
            threshold_reg    <= THRESHOLD_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_COEFFICIENT:      coef_reg         <= cfg_data[COEF_W-1:0];
                CFG_BLOCK_LENGTH:     block_length_reg <= cfg_data[LEN_W-1:0];
                CFG_ENERGY_THRESHOLD: threshold_reg    <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // resonator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_one_reg <= '0;
            delay_two_reg <= '0;
            counter_reg   <= '0;
        end else if (res_update) begin
            delay_two_reg <= delay_one_reg;
            delay_one_reg <= q0_sat;
            counter_reg   <= cnt_inc;
        end else if (result_load) begin
            delay_one_reg <= '0;
            delay_two_reg <= '0;
            counter_reg   <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg <= s_sample;
        end
        if (cq_load) begin
            cq_reg <= mac_acc[CQ_W-1:0];
        end
        if (result_load) begin
            energy_reg <= energy_sat;
            tone_reg   <= (energy_sat > threshold_reg);
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_block_energy = energy_reg;
    assign m_tone_present = tone_reg;

endmodule

// File: hw/rtl/gtd_mac.sv
// Shared multiply-accumulate unit: registered 21x21 signed multiply, then
// shift-and-add into a wide accumulator. Depends on gtd_pkg.
`timescale 1ns / 1ps

module gtd_mac (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  gtd_pkg::mac_op_t                 op,
    output logic                             busy,
    output logic signed [gtd_pkg::ACC_W-1:0] acc
);
    import gtd_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic                     first_reg;
    logic                     rnd_reg;
    logic                     neg_reg;
    shift_t                   shift_reg;

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  prod_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg <= op.valid;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg  <= op.a * op.b;
        first_reg <= op.first;
        rnd_reg   <= op.rnd;
        neg_reg   <= op.neg;
        shift_reg <= op.shift;
    end

    always_comb begin
        prod_ext = ACC_W'(prod_reg);
        case (shift_reg)
            SH_0:    term = prod_ext;
            SH_F:    term = prod_ext <<< COEF_FRAC_BITS;
            SH_20:   term = prod_ext <<< LIMB_W;
            SH_20F:  term = prod_ext <<< (LIMB_W + COEF_FRAC_BITS);
            SH_40:   term = prod_ext <<< (2 * LIMB_W);
            SH_40F:  term = prod_ext <<< (2 * LIMB_W + COEF_FRAC_BITS);
            SH_60:   term = prod_ext <<< (3 * LIMB_W);
            default: term = prod_ext;
        endcase

        if (first_reg) begin
            base = rnd_reg ? (ACC_W'(1) <<< (COEF_FRAC_BITS - 1)) : '0;
        end else begin
            base = acc_reg;
        end

        acc_next = neg_reg ? (base - term) : (base + term);
    end

    always_ff @(posedge aclk) begin
        if (prod_valid_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign busy = prod_valid_reg;
    assign acc  = acc_reg;

endmodule
